// ----- src/wsfd_pkg.sv -----
// Shared types, constants and helper functions for the weather sensor frame decoder.
// No dependencies; imported by weather_sensor_frame_decoder and wsfd_checker.
package wsfd_pkg;

	localparam logic [7:0] CRC_POLY     = 8'h31;
	localparam logic [3:0] START_NIBBLE = 4'h9;
	localparam logic [6:0] HUM_NONE     = 7'h6A;
	localparam logic [6:0] HUM_PROBE2   = 7'h7D;
	localparam logic [6:0] HUM_MAX      = 7'd100;

	// temperature offsets and windows, in raw tenths
	localparam logic [11:0] STD_OFFSET  = 12'd400;
	localparam logic [11:0] ALT_OFFSET  = 12'd500;
	localparam logic [11:0] WIN_LO_500  = 12'd100;   // -40.0 C with 500 offset
	localparam logic [11:0] WIN_HI_500  = 12'd1100;  // +60.0 C with 500 offset
	localparam logic [15:0] RC_MAX      = 16'd1000;
	localparam logic [10:0] TD_MAX      = 11'd1000;

	localparam logic signed [11:0] TEMP_MIN = -12'sd400;
	localparam logic signed [11:0] TEMP_MAX = 12'sd1265;
	localparam logic signed [7:0]  HUM_ABSENT = -8'sd1;

	localparam logic [1:0] CH_NONE   = 2'd0;
	localparam logic [1:0] CH_PROBE1 = 2'd1;
	localparam logic [1:0] CH_PROBE2 = 2'd2;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_CSUM_FAIL = 2'd1,
		ST_BAD_START = 2'd2,
		ST_NO_TEMP   = 2'd3
	} status_t;

	// CRC-8, MSB first, one byte
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] v);
		logic [7:0] crc;
		logic [7:0] d;
		logic       top;
		crc = crc_in;
		d   = v;
		for (int i = 0; i < 8; i++) begin
			top = crc[7] ^ d[7];
			crc = {crc[6:0], 1'b0};
			if (top)
				crc = crc ^ CRC_POLY;
			d = {d[6:0], 1'b0};
		end
		return crc;
	endfunction

	// three nibble digits as d2*100 + d1*10 + d0, nibbles used as is
	function automatic logic [10:0] digits3(input logic [3:0] d2, input logic [3:0] d1,
		input logic [3:0] d0);
		return 11'(d2) * 11'd100 + 11'(d1) * 11'd10 + 11'(d0);
	endfunction

endpackage

// ----- src/weather_sensor_frame_decoder.sv -----
// Weather sensor frame decoder: input register, single-pass decode, result register.
// Depends on wsfd_pkg.
//
// Usage:
//  Input channel (in_valid/in_ready) carries one five-byte radio frame per beat on
//  byte_0..byte_4. Output channel (out_valid/out_ready) carries one decoded result
//  per frame: accepted, status, alt_protocol, sensor_id, battery flags, temp_tenths,
//  humidity and channel.
//  out_valid rises once the input beat has passed the input register and then the
//  result register. Throughput: one frame per cycle while out_ready stays high; CRC-8,
//  checksum and the temperature candidates are all evaluated in the one decode stage.
//  A new frame is taken while a finished result waits: the input register holds
//  one frame while the result register is stalled, so in_ready drops only when
//  both are full and out_ready is low.
//  Reset (arst_n low) empties both stages; no frame is in flight afterwards.
//  A stalled receiver loses nothing: results hold until out_ready is seen.
module weather_sensor_frame_decoder
	import wsfd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         byte_0,
	input  logic [7:0]         byte_1,
	input  logic [7:0]         byte_2,
	input  logic [7:0]         byte_3,
	input  logic [7:0]         byte_4,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               accepted,
	output logic [1:0]         status,
	output logic               alt_protocol,
	output logic [5:0]         sensor_id,
	output logic               new_battery,
	output logic               weak_battery,
	output logic signed [11:0] temp_tenths,
	output logic signed [7:0]  humidity,
	output logic [1:0]         channel
);

	// stage 1: frame register
	logic       valid_s1;
	logic [7:0] b0_s1, b1_s1, b2_s1, b3_s1, b4_s1;

	// stage 2: result register
	logic               valid_s2;
	logic               acc_s2;
	status_t            st_s2;
	logic               alt_s2;
	logic [5:0]         id_s2;
	logic               nb_s2;
	logic               wb_s2;
	logic signed [11:0] temp_s2;
	logic signed [7:0]  hum_s2;
	logic [1:0]         ch_s2;

	logic adv_s2;
	logic load_s1;

	assign adv_s2   = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || adv_s2;
	assign load_s1  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			b0_s1 <= byte_0;
			b1_s1 <= byte_1;
			b2_s1 <= byte_2;
			b3_s1 <= byte_3;
			b4_s1 <= byte_4;
		end
	end

	// ---------------- decode ----------------
	logic       std_path;
	logic [7:0] crc;
	logic [6:0] hraw;
	logic [10:0] std_raw;

	logic [7:0]  xsum;
	logic        xsum_ok;
	logic [11:0] ta_raw, tb_raw;
	logic [15:0] rc_raw;
	logic [10:0] td_raw;
	logic        ta_ok, tb_ok, rc_ok, td_ok;

	logic               acc_d;
	status_t            st_d;
	logic [5:0]         id_d;
	logic               nb_d;
	logic               wb_d;
	logic signed [11:0] temp_d;
	logic signed [7:0]  hum_d;
	logic [1:0]         ch_d;

	assign std_path = (b0_s1[7:4] == START_NIBBLE);
	assign crc = crc8_byte(crc8_byte(crc8_byte(crc8_byte(8'h00, b0_s1), b1_s1), b2_s1), b3_s1);
	assign hraw = b3_s1[6:0];
	assign std_raw = digits3(b1_s1[3:0], b2_s1[7:4], b2_s1[3:0]);

	// alternate path: XOR checksum within +-1 of byte 4
	assign xsum    = b0_s1 ^ b1_s1 ^ b2_s1 ^ b3_s1;
	assign xsum_ok = ({1'b0, xsum} == {1'b0, b4_s1}) ||
		({1'b0, xsum} == {1'b0, b4_s1} + 9'd1) ||
		({1'b0, xsum} + 9'd1 == {1'b0, b4_s1});

	assign ta_raw = {b1_s1[3:0], b2_s1};
	assign tb_raw = {b2_s1, b3_s1[7:4]};
	assign rc_raw = {b2_s1, b3_s1};
	assign td_raw = digits3(b2_s1[7:4], b2_s1[3:0], b3_s1[7:4]);
	assign ta_ok  = (ta_raw >= WIN_LO_500) && (ta_raw <= WIN_HI_500);
	assign tb_ok  = (tb_raw >= WIN_LO_500) && (tb_raw <= WIN_HI_500);
	assign rc_ok  = (rc_raw <= RC_MAX);
	assign td_ok  = (td_raw <= TD_MAX);

	always_comb begin
		acc_d  = 1'b0;
		st_d   = ST_OK;
		id_d   = '0;
		nb_d   = 1'b0;
		wb_d   = 1'b0;
		temp_d = '0;
		hum_d  = '0;
		ch_d   = CH_NONE;
		if (std_path) begin
			acc_d  = (crc == b4_s1);
			st_d   = acc_d ? ST_OK : ST_CSUM_FAIL;
			id_d   = {b0_s1[3:0], b1_s1[7:6]};
			nb_d   = b1_s1[5];
			wb_d   = b3_s1[7];
			temp_d = $signed({1'b0, std_raw} - STD_OFFSET);
			hum_d  = HUM_ABSENT;
			ch_d   = CH_PROBE1;
			if (hraw == HUM_PROBE2)
				ch_d = CH_PROBE2;
			else if (hraw != HUM_NONE && hraw <= HUM_MAX)
				hum_d = $signed({1'b0, hraw});
		end else if (!xsum_ok) begin
			st_d = ST_CSUM_FAIL;
		end else if (ta_ok || tb_ok || rc_ok || td_ok) begin
			// first candidate format in the window wins
			if (ta_ok)
				temp_d = $signed(ta_raw - ALT_OFFSET);
			else if (tb_ok)
				temp_d = $signed(tb_raw - ALT_OFFSET);
			else if (rc_ok)
				temp_d = $signed(rc_raw[11:0] - STD_OFFSET);
			else
				temp_d = $signed({1'b0, td_raw} - STD_OFFSET);
			acc_d = 1'b1;
			id_d  = b0_s1[7:2];
			nb_d  = b0_s1[7];
			wb_d  = b3_s1[3];
			hum_d = HUM_ABSENT;
			ch_d  = CH_PROBE1;
		end else begin
			st_d = ST_NO_TEMP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			acc_s2  <= acc_d;
			st_s2   <= st_d;
			alt_s2  <= !std_path;
			id_s2   <= id_d;
			nb_s2   <= nb_d;
			wb_s2   <= wb_d;
			temp_s2 <= temp_d;
			hum_s2  <= hum_d;
			ch_s2   <= ch_d;
		end
	end

	assign out_valid    = valid_s2;
	assign accepted     = acc_s2;
	assign status       = st_s2;
	assign alt_protocol = alt_s2;
	assign sensor_id    = id_s2;
	assign new_battery  = nb_s2;
	assign weak_battery = wb_s2;
	assign temp_tenths  = temp_s2;
	assign humidity     = hum_s2;
	assign channel      = ch_s2;

endmodule

// ----- src/wsfd_checker.sv -----
// Port-level checks for weather_sensor_frame_decoder, bound to the top level.
// Depends on wsfd_pkg.
module wsfd_checker
	import wsfd_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic               accepted,
	input logic [1:0]         status,
	input logic               alt_protocol,
	input logic [5:0]         sensor_id,
	input logic               new_battery,
	input logic               weak_battery,
	input logic signed [11:0] temp_tenths,
	input logic signed [7:0]  humidity,
	input logic [1:0]         channel
);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(temp_tenths) && $stable(status))
		else $error("result beat dropped or changed under stall");

	// accepted frames always carry OK status and an in-range temperature
	a_acc_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && accepted |->
			status == ST_OK && temp_tenths >= TEMP_MIN && temp_tenths <= TEMP_MAX)
		else $error("accepted frame with bad status or temperature");

	// alternate-path failure zeroes all decoded fields
	a_alt_fail: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && alt_protocol && !accepted |->
			sensor_id == 6'd0 && !new_battery && !weak_battery && temp_tenths == 12'sd0 &&
			humidity == 8'sd0 && channel == CH_NONE &&
			(status == ST_CSUM_FAIL || status == ST_NO_TEMP))
		else $error("alternate-path failure with nonzero fields");

	// standard path never reports a bad start or missing temperature
	a_std_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !alt_protocol |->
			(status == ST_OK || status == ST_CSUM_FAIL) && channel != CH_NONE)
		else $error("standard path with impossible status or channel");

endmodule

bind weather_sensor_frame_decoder wsfd_checker u_wsfd_checker (.*);

// ----- tb/testbench.sv -----
// Self-checking testbench for weather_sensor_frame_decoder: standard CRC-8 frames and
// alternate XOR-checksum frames, predicted in-line and checked field by field.
// Depends on wsfd_pkg and the decoder RTL.
`timescale 1ns / 100ps

module testbench;
	import wsfd_pkg::*;

	localparam int STD_BIAS      = 400;
	localparam int ALT_BIAS      = 500;
	localparam int SPAN_LO       = -400;
	localparam int SPAN_HI       = 600;
	localparam int RAW_SPAN_MAX  = 1000;
	localparam int PHASE_FRAMES  = 400;
	localparam int STALL_LIMIT   = 4000;
	localparam int DRAIN_CYCLES  = 10;
	localparam int REPORT_MAX    = 10;

	typedef struct packed {
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
		logic [7:0] b3;
		logic [7:0] b4;
	} frame_t;

	typedef struct packed {
		logic               accepted;
		status_t            status;
		logic               alt_protocol;
		logic [5:0]         sensor_id;
		logic               new_battery;
		logic               weak_battery;
		logic signed [11:0] temp_tenths;
		logic signed [7:0]  humidity;
		logic [1:0]         channel;
	} result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [7:0]         byte_0 = '0;
	logic [7:0]         byte_1 = '0;
	logic [7:0]         byte_2 = '0;
	logic [7:0]         byte_3 = '0;
	logic [7:0]         byte_4 = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic               accepted;
	logic [1:0]         status;
	logic               alt_protocol;
	logic [5:0]         sensor_id;
	logic               new_battery;
	logic               weak_battery;
	logic signed [11:0] temp_tenths;
	logic signed [7:0]  humidity;
	logic [1:0]         channel;

	frame_t  frame_queue[$];
	result_t expected_results[$];
	frame_t  held_frame;
	result_t predicted;
	result_t want, got;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int frames_queued = 0;
	int frames_taken = 0;
	int results_seen = 0;
	int error_count = 0;
	int idle_cycles = 0;
	int std_frames = 0;
	int alt_frames = 0;
	int good_frames = 0;
	int csum_fails = 0;
	int no_temp_fails = 0;

	weather_sensor_frame_decoder uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.byte_0       (byte_0),
		.byte_1       (byte_1),
		.byte_2       (byte_2),
		.byte_3       (byte_3),
		.byte_4       (byte_4),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.accepted     (accepted),
		.status       (status),
		.alt_protocol (alt_protocol),
		.sensor_id    (sensor_id),
		.new_battery  (new_battery),
		.weak_battery (weak_battery),
		.temp_tenths  (temp_tenths),
		.humidity     (humidity),
		.channel      (channel)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// CRC-8 over bytes 0..3, MSB first, zero init
	function automatic logic [7:0] frame_crc(frame_t f);
		logic [7:0]  crc;
		logic [31:0] sr;
		logic        fb;
		crc = 8'h00;
		sr = {f.b0, f.b1, f.b2, f.b3};
		for (int i = 0; i < 32; i++) begin
			fb = crc[7] ^ sr[31];
			crc = {crc[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
			sr = sr << 1;
		end
		return crc;
	endfunction

	function automatic bit in_span(int t);
		return t >= SPAN_LO && t <= SPAN_HI;
	endfunction

	function automatic result_t decode_frame(frame_t f);
		result_t    r;
		logic [6:0] hcode;
		logic [7:0] x;
		int         slack, ta, tb, rc, td;
		r = '0;
		r.status = ST_OK;
		if (f.b0[7:4] == START_NIBBLE) begin
			r.accepted = (frame_crc(f) == f.b4);
			r.status = r.accepted ? ST_OK : ST_CSUM_FAIL;
			r.sensor_id = {f.b0[3:0], f.b1[7:6]};
			r.new_battery = f.b1[5];
			r.weak_battery = f.b3[7];
			r.temp_tenths = 12'(int'(f.b1[3:0]) * 100 + int'(f.b2[7:4]) * 10
				+ int'(f.b2[3:0]) - STD_BIAS);
			hcode = f.b3[6:0];
			r.channel = CH_PROBE1;
			r.humidity = HUM_ABSENT;
			if (hcode == HUM_PROBE2)
				r.channel = CH_PROBE2;
			else if (hcode != HUM_NONE && hcode <= HUM_MAX)
				r.humidity = 8'(hcode);
		end else begin
			r.alt_protocol = 1'b1;
			x = f.b0 ^ f.b1 ^ f.b2 ^ f.b3;
			slack = int'(x) - int'(f.b4);
			if (slack > 1 || slack < -1) begin
				r.status = ST_CSUM_FAIL;
			end else begin
				ta = int'({f.b1[3:0], f.b2}) - ALT_BIAS;
				tb = int'({f.b2, f.b3[7:4]}) - ALT_BIAS;
				rc = int'({f.b2, f.b3});
				td = int'(f.b2[7:4]) * 100 + int'(f.b2[3:0]) * 10 + int'(f.b3[7:4])
					- STD_BIAS;
				r.accepted = 1'b1;
				r.sensor_id = f.b0[7:2];
				r.new_battery = f.b0[7];
				r.weak_battery = f.b3[3];
				r.humidity = HUM_ABSENT;
				r.channel = CH_PROBE1;
				// candidate formats in priority order
				if (in_span(ta))
					r.temp_tenths = 12'(ta);
				else if (in_span(tb))
					r.temp_tenths = 12'(tb);
				else if (rc <= RAW_SPAN_MAX)
					r.temp_tenths = 12'(rc - STD_BIAS);
				else if (in_span(td))
					r.temp_tenths = 12'(td);
				else begin
					r = '0;
					r.alt_protocol = 1'b1;
					r.status = ST_NO_TEMP;
				end
			end
		end
		return r;
	endfunction

	function automatic frame_t seal_std(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2,
		logic [7:0] b3);
		frame_t f;
		f = '{b0, b1, b2, b3, 8'h00};
		f.b0[7:4] = START_NIBBLE;
		f.b4 = frame_crc(f);
		return f;
	endfunction

	// alternate frame with checksum off by the given slack (flipped if out of byte range)
	function automatic frame_t seal_alt(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2,
		logic [7:0] b3, int slack);
		frame_t f;
		int     sum;
		f = '{b0, b1, b2, b3, 8'h00};
		if (f.b0[7:4] == START_NIBBLE)
			f.b0[4] = ~f.b0[4];
		sum = int'(f.b0 ^ f.b1 ^ f.b2 ^ f.b3) - slack;
		if (sum < 0 || sum > 255)
			sum = int'(f.b0 ^ f.b1 ^ f.b2 ^ f.b3) + slack;
		f.b4 = 8'(sum);
		return f;
	endfunction

	function automatic frame_t random_frame();
		frame_t     f;
		int         pick, slack;
		logic [7:0] r0, r1, r2, r3;
		pick = $urandom_range(99);
		r0 = 8'($urandom);
		r1 = 8'($urandom);
		r2 = 8'($urandom);
		r3 = 8'($urandom);
		if (pick < 50) begin
			if ($urandom_range(4) == 0) begin
				case ($urandom_range(3))
					0: r3[6:0] = HUM_NONE;
					1: r3[6:0] = HUM_PROBE2;
					2: r3[6:0] = HUM_MAX;
					default: r3[6:0] = HUM_MAX + 7'd1;
				endcase
			end
			f = seal_std(r0, r1, r2, r3);
			if (pick >= 40)
				f.b4 = 8'($urandom);
		end else if (pick < 85) begin
			// push some frames past the first temperature format
			if ($urandom_range(2) == 0)
				r1[3:0] = 4'hF;
			if ($urandom_range(9) == 0)
				slack = $urandom_range(1) ? 2 : -2;
			else
				slack = int'($urandom_range(2)) - 1;
			f = seal_alt(r0, r1, r2, r3, slack);
		end else begin
			f = '{r0, r1, r2, r3, 8'($urandom)};
		end
		return f;
	endfunction

	task automatic push_frame(frame_t f);
		frame_queue.push_back(f);
		frames_queued++;
	endtask

	task automatic push_directed();
		frame_t f;
		push_frame(seal_alt(8'h00, 8'h00, 8'h00, 8'h00, 0));
		push_frame('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
		push_frame(seal_std(8'h90, 8'h00, 8'h00, 8'h00));
		push_frame(seal_std(8'h9F, 8'hFF, 8'hFF, 8'hE4));
		push_frame(seal_std(8'h93, 8'h46, 8'h21, 8'h6A));
		push_frame(seal_std(8'h95, 8'h8A, 8'h99, 8'hFD));
		push_frame(seal_std(8'h9A, 8'h12, 8'h34, 8'h65));
		push_frame(seal_std(8'h9C, 8'hD5, 8'h50, 8'h7F));
		push_frame(seal_std(8'h96, 8'h46, 8'h21, 8'h32));
		f = seal_std(8'h91, 8'h73, 8'h18, 8'h2D);
		f.b4 = f.b4 ^ 8'h01;
		push_frame(f);
		push_frame(seal_alt(8'h5C, 8'h02, 8'hBC, 8'h08, 0));
		push_frame(seal_alt(8'hA4, 8'h0F, 8'h40, 8'h00, 1));
		push_frame(seal_alt(8'h13, 8'h0F, 8'h00, 8'h10, -1));
		push_frame(seal_alt(8'hFC, 8'h3F, 8'h70, 8'h00, 0));
		push_frame(seal_alt(8'h20, 8'h0F, 8'hFF, 8'hFF, 0));
		push_frame(seal_alt(8'h44, 8'h21, 8'h33, 8'h55, 2));
		push_frame(seal_alt(8'h44, 8'h21, 8'h33, 8'h55, -2));
		// window edges of the first format, and one step past the top
		push_frame(seal_alt(8'h88, 8'h00, 8'h64, 8'hF7, 0));
		push_frame(seal_alt(8'h8B, 8'hF4, 8'h4C, 8'h00, 1));
		push_frame(seal_alt(8'hA0, 8'h04, 8'h4D, 8'h0F, -1));
		push_frame(seal_alt(8'h7F, 8'h80, 8'h00, 8'h00, 0));
	endtask

	// driver: next frame goes out once the current beat is taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				predicted = decode_frame(held_frame);
				expected_results.push_back(predicted);
				frames_taken++;
				if (predicted.alt_protocol)
					alt_frames++;
				else
					std_frames++;
				if (predicted.accepted)
					good_frames++;
				else if (predicted.status == ST_NO_TEMP)
					no_temp_fails++;
				else
					csum_fails++;
			end
			if (!in_valid || in_ready) begin
				if (frame_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					held_frame = frame_queue.pop_front();
					in_valid <= 1'b1;
					byte_0 <= held_frame.b0;
					byte_1 <= held_frame.b1;
					byte_2 <= held_frame.b2;
					byte_3 <= held_frame.b3;
					byte_4 <= held_frame.b4;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: compare each result beat with the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
			if (out_valid && out_ready) begin
				results_seen++;
				got.accepted = accepted;
				got.status = status_t'(status);
				got.alt_protocol = alt_protocol;
				got.sensor_id = sensor_id;
				got.new_battery = new_battery;
				got.weak_battery = weak_battery;
				got.temp_tenths = temp_tenths;
				got.humidity = humidity;
				got.channel = channel;
				if (expected_results.size() == 0) begin
					error_count++;
					if (error_count <= REPORT_MAX)
						$display("%0t: result beat with nothing expected", $realtime);
				end else begin
					want = expected_results.pop_front();
					if (got !== want) begin
						error_count++;
						if (error_count <= REPORT_MAX) begin
							$display("%0t: result %0d mismatch (exp/got):",
								$realtime, results_seen);
							$display("  acc %0b/%0b st %0d/%0d alt %0b/%0b id %0d/%0d",
								want.accepted, got.accepted, want.status, got.status,
								want.alt_protocol, got.alt_protocol,
								want.sensor_id, got.sensor_id);
							$display("  nb %0b/%0b wb %0b/%0b temp %0d/%0d hum %0d/%0d",
								want.new_battery, got.new_battery,
								want.weak_battery, got.weak_battery,
								want.temp_tenths, got.temp_tenths,
								want.humidity, got.humidity);
							$display("  ch %0d/%0d", want.channel, got.channel);
						end
					end
				end
			end
		end
	end

	// watchdog on cycles without any beat on either channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $realtime, STALL_LIMIT);
				$display("testbench: errors");
				$finish;
			end
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		for (int phase = 0; phase < 4; phase++) begin
			@(negedge clk);
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
				default: begin send_idle_pct = 6; recv_stall_pct = 6; end
			endcase
			if (phase == 0)
				push_directed();
			repeat (PHASE_FRAMES) push_frame(random_frame());
			while (frame_queue.size() != 0)
				@(negedge clk);
		end
		while (frames_taken != frames_queued)
			@(negedge clk);
		while (expected_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (expected_results.size() != 0) begin
			error_count += expected_results.size();
			$display("%0d predicted results never arrived", expected_results.size());
		end
		$display("summary: %0d frames (%0d standard, %0d alternate), %0d results checked",
			frames_taken, std_frames, alt_frames, results_seen);
		$display("summary: %0d decoded ok, %0d checksum failures, %0d without temperature",
			good_frames, csum_fails, no_temp_fails);
		if (error_count == 0) begin
			$display("testbench: clean");
		end else begin
			$display("%0d mismatches", error_count);
			$display("testbench: errors");
		end
		$finish;
	end

endmodule
